### src/ksrp_pkg.sv
// Shared types, codes and constants of the keyed symbol radix packer.
package ksrp_pkg;

  localparam logic [7:0] KEY_DEPTH = 8'd255;
  localparam logic [6:0] DPW_RESET = 7'd8;

  localparam logic OP_KEY    = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] symbol;
    logic       is_last;
  } sym_item_t;

  typedef struct packed {
    logic [63:0] packed_word;
    logic [6:0]  digit_count;
    logic        not_in_key;
  } word_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC
  } state_t;

  typedef struct packed {
    logic key_write;
    logic lookup;
    logic mul_en;
    logic acc_en;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

### src/ksrp_ctrl.sv
// Controller state machine sequencing key appends, lookups, multiplies and accumulation.
module ksrp_ctrl
  import ksrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      sym_valid,
  input  logic      sym_operation,
  output logic      sym_stall,
  input  logic      word_stall,
  input  status_t   status,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    out_free   = !status.out_valid || !word_stall;
    sym_stall  = !((state == ST_IDLE) || ((state == ST_ACC) && out_free));
    accept     = sym_valid && !sym_stall;
    state_next = state;
    cmd.key_write = accept && (sym_operation == OP_KEY);
    cmd.lookup    = accept && (sym_operation == OP_ENCODE);
    cmd.mul_en    = 1'b0;
    cmd.acc_en    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd.lookup) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (out_free) begin
          cmd.acc_en = 1'b1;
          state_next = cmd.lookup ? ST_MUL : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/ksrp_datapath.sv
// Datapath: inverse key table, radix multipliers, word accumulator and output register.
module ksrp_datapath
  import ksrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sym_item_t  sym_item,
  input  logic       cfg_valid,
  input  logic [6:0] cfg_data,
  input  logic       word_stall,
  input  cmd_t       cmd,
  output status_t    status,
  output logic       word_valid,
  output word_item_t word_item
);

  logic [7:0]   pos_mem [256];
  logic [255:0] present;
  logic [7:0]   key_fill;
  logic [6:0]   digits_per_word;
  logic [7:0]   rd_pos;
  logic         rd_hit;
  logic         last;
  logic [63:0]  word_acc;
  logic [63:0]  place;
  logic [6:0]   held;
  logic [63:0]  prod_word;
  logic [63:0]  prod_place;
  logic         hit;
  logic [71:0]  mul_word;
  logic [72:0]  mul_place;
  logic [8:0]   radix;
  logic [7:0]   digit;
  logic [63:0]  sum;
  logic [6:0]   held_inc;
  logic [6:0]   limit;
  logic         emit;
  logic         new_key;

  assign new_key = cmd.key_write && !present[sym_item.symbol] && (key_fill < KEY_DEPTH);

  always_ff @(posedge clk) begin
    if (new_key) begin
      pos_mem[sym_item.symbol] <= key_fill + 8'd1;
    end
    if (cmd.lookup) begin
      rd_pos <= pos_mem[sym_item.symbol];
      rd_hit <= present[sym_item.symbol];
      last   <= sym_item.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present  <= '0;
      key_fill <= '0;
    end else if (cmd.key_write && (key_fill < KEY_DEPTH)) begin
      key_fill <= key_fill + 8'd1;
      if (new_key) begin
        present[sym_item.symbol] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits_per_word <= DPW_RESET;
    end else if (cfg_valid) begin
      digits_per_word <= cfg_data;
    end
  end

  always_comb begin
    radix     = {1'b0, key_fill} + 9'd1;
    digit     = rd_hit ? rd_pos : 8'd0;
    mul_word  = place * digit;
    mul_place = place * radix;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_word  <= mul_word[63:0];
      prod_place <= mul_place[63:0];
      hit        <= rd_hit;
    end
  end

  always_comb begin
    sum      = word_acc + prod_word;
    held_inc = held + 7'd1;
    limit    = (digits_per_word == 7'd0) ? 7'd1 : digits_per_word;
    emit     = (held_inc >= limit) || last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_acc <= '0;
      place    <= 64'd1;
      held     <= '0;
    end else if (cmd.acc_en) begin
      if (!hit || emit) begin
        word_acc <= '0;
        place    <= 64'd1;
        held     <= '0;
      end else begin
        word_acc <= sum;
        place    <= prod_place;
        held     <= held_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (cmd.acc_en && (!hit || emit)) begin
      word_valid <= 1'b1;
    end else if (!word_stall) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && (!hit || emit)) begin
      if (!hit) begin
        word_item <= '{packed_word: 64'd0, digit_count: 7'd0, not_in_key: 1'b1};
      end else begin
        word_item <= '{packed_word: sum, digit_count: held_inc, not_in_key: 1'b0};
      end
    end
  end

  assign status.out_valid = word_valid;

endmodule

### src/keyed_symbol_radix_packer.sv
// Key append: gives no result; a key byte can follow every cycle while no encode stalls the input.
// Encode: the inverse-table read is registered as the request is taken, then the multiply,
// then the add into the output register; a new encode can be taken along with the add step.
// A result held by a stalled output keeps the add step, and with it the input, waiting.
// Reset clears the key (256 presence flags cleared at once), the partial word and the
// output valid flag, and sets digits_per_word to 8; no clearing pass is needed.
module keyed_symbol_radix_packer
  import ksrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       sym_valid,
  output logic       sym_stall,
  input  sym_item_t  sym_item,
  output logic       word_valid,
  input  logic       word_stall,
  output word_item_t word_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ksrp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .sym_valid     (sym_valid),
    .sym_operation (sym_item.operation),
    .sym_stall     (sym_stall),
    .word_stall    (word_stall),
    .status        (status),
    .cmd           (cmd)
  );

  ksrp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .sym_item   (sym_item),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .word_stall (word_stall),
    .cmd        (cmd),
    .status     (status),
    .word_valid (word_valid),
    .word_item  (word_item)
  );

`ifndef SYNTH
  // An error result carries an empty word.
  assert property (@(posedge clk) disable iff (rst)
    word_valid && word_item.not_in_key |->
      (word_item.packed_word == 64'd0) && (word_item.digit_count == 7'd0))
    else $error("error result with non-empty word");

  // A packed word always holds at least one digit.
  assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_item.not_in_key |-> (word_item.digit_count != 7'd0))
    else $error("packed word with no digits");

  // An accepted encode request keeps the input stalled in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    sym_valid && !sym_stall && (sym_item.operation == OP_ENCODE) |=> sym_stall)
    else $error("input not stalled during encode");
`endif

endmodule
